// ----- hw/rtl/mlt_pkg.sv -----
// ----------------------------------------------------------------------------
// mlt_pkg
// shared codes and controller/datapath handshake types for the learning table
// ----------------------------------------------------------------------------
package mlt_pkg;

  localparam logic [2:0] FUNC_LEARN  = 3'd0;
  localparam logic [2:0] FUNC_LOOKUP = 3'd1;
  localparam logic [2:0] FUNC_DELETE = 3'd2;
  localparam logic [2:0] FUNC_AGE    = 3'd3;
  localparam logic [2:0] FUNC_CLEAR  = 3'd4;

  localparam logic [1:0] REG_LONG_TIMEOUT  = 2'd0;
  localparam logic [1:0] REG_SHORT_TIMEOUT = 2'd1;
  localparam logic [1:0] REG_CROWD_LEVEL   = 2'd2;
  localparam logic [1:0] REG_ENTRY_LIMIT   = 2'd3;

  localparam int unsigned MacW   = 48;
  localparam int unsigned PortW  = 3;
  localparam int unsigned TickW  = 32;
  localparam int unsigned OutCntW = 9;
  localparam int unsigned McastBit = 40;

  typedef struct packed {
    logic load;
    logic age_init;
    logic age_rd;
    logic chk_rd;
    logic find_init;
    logic find_rd;
    logic act;
  } cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       out_busy;
  } sts_t;

endpackage

// ----- hw/rtl/mlt_ram.sv -----
// ----------------------------------------------------------------------------
// mlt_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module mlt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/mlt_ctrl.sv -----
// ----------------------------------------------------------------------------
// mlt_ctrl
// sequencer: aging scan, per-bucket expiry check, match scan, update
// ----------------------------------------------------------------------------
module mlt_ctrl #(
  parameter int unsigned Entries = 256,
  parameter int unsigned Buckets = 16,
  parameter int unsigned CntW    = 9
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  mlt_pkg::sts_t   sts_i,
  output mlt_pkg::cmd_t   cmd_o,
  output logic [CntW-1:0] cnt_o
);
  import mlt_pkg::*;

  localparam logic [2:0] StIdle     = 3'd0;
  localparam logic [2:0] StDispatch = 3'd1;
  localparam logic [2:0] StAgeScan  = 3'd2;
  localparam logic [2:0] StAgeDrain = 3'd3;
  localparam logic [2:0] StChk      = 3'd4;
  localparam logic [2:0] StChkDrain = 3'd5;
  localparam logic [2:0] StFind     = 3'd6;
  localparam logic [2:0] StAct      = 3'd7;

  logic [2:0]      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            find_drain_q, find_drain_d;

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    find_drain_d = find_drain_q;
    cmd_o        = '0;
    in_ready_o   = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StDispatch;
        end
      end
      StDispatch: begin
        cnt_d = '0;
        if (sts_i.func == FUNC_LEARN || sts_i.func == FUNC_AGE) begin
          cmd_o.age_init = 1'b1;
          state_d        = StAgeScan;
        end else if (sts_i.func == FUNC_LOOKUP || sts_i.func == FUNC_DELETE) begin
          cmd_o.find_init = 1'b1;
          find_drain_d    = 1'b0;
          state_d         = StFind;
        end else begin
          state_d = StAct;
        end
      end
      StAgeScan: begin
        cmd_o.age_rd = 1'b1;
        cnt_d        = cnt_q + 1'b1;
        if (cnt_q == CntW'(Entries - 1)) begin
          state_d = StAgeDrain;
        end
      end
      StAgeDrain: begin
        cnt_d   = '0;
        state_d = StChk;
      end
      StChk: begin
        cmd_o.chk_rd = 1'b1;
        cnt_d        = cnt_q + 1'b1;
        if (cnt_q == CntW'(Buckets - 1)) begin
          state_d = StChkDrain;
        end
      end
      StChkDrain: begin
        cnt_d = '0;
        if (sts_i.func == FUNC_LEARN) begin
          cmd_o.find_init = 1'b1;
          find_drain_d    = 1'b0;
          state_d         = StFind;
        end else begin
          state_d = StAct;
        end
      end
      StFind: begin
        if (find_drain_q) begin
          state_d = StAct;
        end else begin
          cmd_o.find_rd = 1'b1;
          cnt_d         = cnt_q + 1'b1;
          if (cnt_q == CntW'(Entries - 1)) begin
            find_drain_d = 1'b1;
          end
        end
      end
      StAct: begin
        if (!sts_i.out_busy) begin
          cmd_o.act = 1'b1;
          state_d   = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      cnt_q        <= '0;
      find_drain_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_q        <= cnt_d;
      find_drain_q <= find_drain_d;
    end
  end

  assign cnt_o = cnt_q;

endmodule

// ----- hw/rtl/mlt_dp.sv -----
// ----------------------------------------------------------------------------
// mlt_dp
// entry storage, bucket oldest tracking, match search and result register
// ----------------------------------------------------------------------------
module mlt_dp #(
  parameter int unsigned Entries = 256,
  parameter int unsigned Buckets = 16,
  parameter int unsigned CntW    = 9
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mlt_pkg::cmd_t   cmd_i,
  input  logic [CntW-1:0] cnt_i,
  output mlt_pkg::sts_t   sts_o,
  input  logic [2:0]      in_func_i,
  input  logic [47:0]     in_mac_i,
  input  logic [2:0]      in_port_i,
  input  logic [31:0]     in_now_i,
  input  logic            cfg_we_i,
  input  logic [1:0]      cfg_index_i,
  input  logic [31:0]     cfg_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            out_forward_o,
  output logic            out_found_o,
  output logic            out_dropped_o,
  output logic [8:0]      out_entry_count_o
);
  import mlt_pkg::*;

  localparam int unsigned AW   = $clog2(Entries);
  localparam int unsigned BW   = (Buckets > 1) ? $clog2(Buckets) : 1;
  localparam int unsigned VW   = $clog2(Entries + 1);
  localparam int unsigned LW   = (VW > 9) ? VW : 9;
  localparam int unsigned RamW = TickW + PortW + MacW;

  // configuration
  logic [31:0] long_tmo_q, short_tmo_q;
  logic [8:0]  crowd_q, limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_tmo_q  <= 32'd300000;
      short_tmo_q <= 32'd500;
      crowd_q     <= 9'd100;
      limit_q     <= 9'd256;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_LONG_TIMEOUT:  long_tmo_q  <= cfg_data_i;
        REG_SHORT_TIMEOUT: short_tmo_q <= cfg_data_i;
        REG_CROWD_LEVEL:   crowd_q     <= cfg_data_i[8:0];
        REG_ENTRY_LIMIT:   limit_q     <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  // current item
  logic [2:0]  func_q;
  logic [47:0] mac_q;
  logic [2:0]  port_q;
  logic [31:0] now_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= in_func_i;
      mac_q  <= in_mac_i;
      port_q <= in_port_i;
      now_q  <= in_now_i;
    end
  end

  // bucket map of the low address byte
  logic [BW-1:0] bkt_tab [256];
  for (genvar g = 0; g < 256; g++) begin : g_bkt
    assign bkt_tab[g] = BW'(g % Buckets);
  end

  // control state
  logic [Entries-1:0] valid_q;
  logic [VW-1:0]      total_q;
  logic [31:0]        rc_q;
  logic [31:0]        tmo_q;

  // scan pipeline
  logic          p_age_q, p_find_q;
  logic [AW-1:0] p_idx_q;
  logic          c_vld_q;
  logic [AW-1:0] c_idx_q;

  logic [RamW-1:0] a_rdata;
  logic [31:0]     s_rdata;
  logic [47:0]     pmac;
  logic [2:0]      pport;
  logic [31:0]     pord;
  logic            pvld;
  logic [BW-1:0]   pb, rb;

  assign pmac  = a_rdata[MacW-1:0];
  assign pport = a_rdata[MacW+PortW-1:MacW];
  assign pord  = a_rdata[RamW-1:MacW+PortW];
  assign pvld  = valid_q[p_idx_q];
  assign pb    = bkt_tab[pmac[7:0]];
  assign rb    = p_age_q ? pb : cnt_i[BW-1:0];

  // oldest entry per bucket
  logic          old_vld_q [Buckets];
  logic [AW-1:0] old_idx_q [Buckets];
  logic [31:0]   old_age_q [Buckets];
  logic [31:0]   age_v;
  logic          old_upd;

  assign age_v   = rc_q - pord;
  assign old_upd = p_age_q && pvld && (!old_vld_q[rb] || age_v > old_age_q[rb]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int b = 0; b < Buckets; b++) begin
        old_vld_q[b] <= 1'b0;
      end
    end else if (cmd_i.age_init) begin
      for (int b = 0; b < Buckets; b++) begin
        old_vld_q[b] <= 1'b0;
      end
    end else if (old_upd) begin
      old_vld_q[rb] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (old_upd) begin
      old_idx_q[rb] <= p_idx_q;
      old_age_q[rb] <= age_v;
    end
  end

  // expiry check
  logic [31:0] diff;
  logic        expire;

  assign diff   = now_q - (s_rdata + tmo_q);
  assign expire = c_vld_q && (diff != 32'd0) && !diff[31];

  // match search
  logic          m_hit_q, f_hit_q;
  logic [AW-1:0] m_idx_q, f_idx_q;
  logic [2:0]    m_port_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_hit_q <= 1'b0;
      f_hit_q <= 1'b0;
    end else if (cmd_i.find_init) begin
      m_hit_q <= 1'b0;
      f_hit_q <= 1'b0;
    end else if (p_find_q) begin
      if (pvld && pmac == mac_q && !m_hit_q) begin
        m_hit_q <= 1'b1;
      end
      if (!pvld && !f_hit_q) begin
        f_hit_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_find_q && pvld && pmac == mac_q && !m_hit_q) begin
      m_idx_q  <= p_idx_q;
      m_port_q <= pport;
    end
    if (p_find_q && !pvld && !f_hit_q) begin
      f_idx_q <= p_idx_q;
    end
  end

  // update step
  logic [LW-1:0] lim, total_x;
  logic          ins_ok, learn_act, do_wr, del_act;
  logic [AW-1:0] w_idx;

  assign total_x   = LW'(total_q);
  assign lim       = (LW'(limit_q) > LW'(Entries)) ? LW'(Entries) : LW'(limit_q);
  assign ins_ok    = !m_hit_q && f_hit_q && (total_x < lim);
  assign learn_act = cmd_i.act && func_q == FUNC_LEARN;
  assign do_wr     = learn_act && (m_hit_q || ins_ok);
  assign del_act   = cmd_i.act && func_q == FUNC_DELETE && m_hit_q;
  assign w_idx     = m_hit_q ? m_idx_q : f_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      total_q  <= '0;
      rc_q     <= '0;
      p_age_q  <= 1'b0;
      p_find_q <= 1'b0;
      c_vld_q  <= 1'b0;
    end else begin
      p_age_q  <= cmd_i.age_rd;
      p_find_q <= cmd_i.find_rd;
      c_vld_q  <= cmd_i.chk_rd && old_vld_q[rb];
      if (cmd_i.act && func_q == FUNC_CLEAR) begin
        valid_q <= '0;
        total_q <= '0;
      end else if (expire || del_act) begin
        valid_q[expire ? c_idx_q : m_idx_q] <= 1'b0;
        if (total_q != '0) begin
          total_q <= total_q - 1'b1;
        end
      end else if (learn_act && ins_ok) begin
        valid_q[f_idx_q] <= 1'b1;
        total_q          <= total_q + 1'b1;
      end
      if (do_wr) begin
        rc_q <= rc_q + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_idx_q <= cnt_i[AW-1:0];
    c_idx_q <= old_idx_q[rb];
    if (cmd_i.age_init) begin
      tmo_q <= (LW'(total_q) > LW'(crowd_q)) ? short_tmo_q : long_tmo_q;
    end
  end

  mlt_ram #(.Width(RamW), .Depth(Entries)) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (do_wr),
    .waddr_i (w_idx),
    .wdata_i ({rc_q, port_q, mac_q}),
    .raddr_i (cnt_i[AW-1:0]),
    .rdata_o (a_rdata)
  );

  mlt_ram #(.Width(TickW), .Depth(Entries)) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (do_wr),
    .waddr_i (w_idx),
    .wdata_i (now_q),
    .raddr_i (old_idx_q[rb]),
    .rdata_o (s_rdata)
  );

  // result register
  logic       out_vld_q;
  logic       fwd_q, fnd_q, drp_q;
  logic [VW-1:0] cnt_nxt;
  logic [LW-1:0] cnt_ext;

  always_comb begin
    cnt_nxt = total_q;
    if (func_q == FUNC_CLEAR) begin
      cnt_nxt = '0;
    end else if (del_act && total_q != '0) begin
      cnt_nxt = total_q - 1'b1;
    end else if (learn_act && ins_ok) begin
      cnt_nxt = total_q + 1'b1;
    end
  end

  assign cnt_ext = LW'(cnt_nxt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.act) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  logic [8:0] ocnt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.act) begin
      fwd_q  <= (func_q == FUNC_LOOKUP) &&
                (mac_q[McastBit] || (m_hit_q && m_port_q == port_q));
      fnd_q  <= (func_q == FUNC_LEARN || func_q == FUNC_LOOKUP ||
                 func_q == FUNC_DELETE) && m_hit_q;
      drp_q  <= (func_q == FUNC_LEARN) && !m_hit_q && !ins_ok;
      ocnt_q <= cnt_ext[8:0];
    end
  end

  assign out_valid_o       = out_vld_q;
  assign out_forward_o     = fwd_q;
  assign out_found_o       = fnd_q;
  assign out_dropped_o     = drp_q;
  assign out_entry_count_o = ocnt_q;

  assign sts_o.func     = func_q;
  assign sts_o.out_busy = out_vld_q && !out_ready_i;

endmodule

// ----- hw/rtl/mac_learning_table.sv -----
// ----------------------------------------------------------------------------
// mac_learning_table
// Learn runs an aging scan of every entry, one per cycle, then one expiry
// check per bucket, then a match scan of every entry; age runs the aging
// scan and the expiry checks; lookup and delete run the match scan; clear
// and unknown codes go straight to the update. One item at a time; the next beat is taken while a
// result still waits. Reset empties the table at once (valid bits in flops).
// ----------------------------------------------------------------------------
module mac_learning_table #(
  parameter int unsigned TABLE_ENTRIES = 256,
  parameter int unsigned BUCKETS       = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [87:0] s_axis_tdata,  // mac[47:0], port[50:48], now[82:51]
  input  logic [2:0]  s_axis_tuser,  // func[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,  // forward, found, dropped, entry_count[11:3]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import mlt_pkg::*;

  localparam int unsigned MaxN = (TABLE_ENTRIES > BUCKETS) ? TABLE_ENTRIES : BUCKETS;
  localparam int unsigned CntW = $clog2(MaxN + 1);

  cmd_t            cmd;
  sts_t            sts;
  logic [CntW-1:0] cnt;
  logic            fwd, fnd, drp;
  logic [8:0]      ecnt;

  assign cfg_ready_o = 1'b1;

  mlt_ctrl #(.Entries(TABLE_ENTRIES), .Buckets(BUCKETS), .CntW(CntW)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .cnt_o      (cnt)
  );

  mlt_dp #(.Entries(TABLE_ENTRIES), .Buckets(BUCKETS), .CntW(CntW)) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .cnt_i             (cnt),
    .sts_o             (sts),
    .in_func_i         (s_axis_tuser),
    .in_mac_i          (s_axis_tdata[47:0]),
    .in_port_i         (s_axis_tdata[50:48]),
    .in_now_i          (s_axis_tdata[82:51]),
    .cfg_we_i          (cfg_valid_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .out_forward_o     (fwd),
    .out_found_o       (fnd),
    .out_dropped_o     (drp),
    .out_entry_count_o (ecnt)
  );

  assign m_axis_tdata = {4'b0, ecnt, drp, fnd, fwd};

endmodule

// ----- dv/mac_learning_table_tb.sv -----
// ----------------------------------------------------------------------------
// mac_learning_table_tb
// Drives learn, lookup, delete, age and clear beats into the learning table
// over several register settings and idle patterns. Each beat is predicted
// and the predicted status is compared field by field with what comes out.
// ----------------------------------------------------------------------------
module mac_learning_table_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mlt_pkg::*;

  localparam int unsigned Entries = 256;
  localparam int unsigned Buckets = 16;
  localparam int unsigned StallLimit = 20000;

  typedef struct packed {
    logic [8:0] entry_count;
    logic       dropped;
    logic       found;
    logic       forward;
  } status_t;

  class table_scoreboard;
    bit          vld[Entries];
    logic [47:0] mac_q[Entries];
    logic [2:0]  port_q[Entries];
    logic [31:0] stamp_q[Entries];
    logic [31:0] order_q[Entries];
    logic [31:0] refresh_cnt;
    int unsigned total;
    logic [31:0] long_tmo, short_tmo;
    logic [8:0]  crowd, limit_reg;
    status_t     pending[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned n_learn, n_drop, n_hit, n_aged;

    function void clear_all();
      foreach (vld[i]) vld[i] = 0;
      refresh_cnt = 0;
      total = 0;
      long_tmo = 300000;
      short_tmo = 500;
      crowd = 100;
      limit_reg = 256;
      pending.delete();
      errors = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_LONG_TIMEOUT:  long_tmo = val;
        REG_SHORT_TIMEOUT: short_tmo = val;
        REG_CROWD_LEVEL:   crowd = val[8:0];
        REG_ENTRY_LIMIT:   limit_reg = val[8:0];
        default: ;
      endcase
    endfunction

    function int find(logic [47:0] m);
      for (int i = 0; i < Entries; i++) if (vld[i] && mac_q[i] == m) return i;
      return -1;
    endfunction

    function void expire(logic [31:0] now);
      int          oldest[Buckets];
      logic [31:0] oage[Buckets];
      logic [31:0] tmo, age, diff;
      int          b;
      tmo = (total > crowd) ? short_tmo : long_tmo;
      for (int k = 0; k < Buckets; k++) begin
        oldest[k] = -1;
        oage[k] = 0;
      end
      for (int i = 0; i < Entries; i++) begin
        if (!vld[i]) continue;
        b = mac_q[i][7:0] % Buckets;
        age = refresh_cnt - order_q[i];
        if (oldest[b] < 0 || age > oage[b]) begin
          oldest[b] = i;
          oage[b] = age;
        end
      end
      for (int k = 0; k < Buckets; k++) begin
        if (oldest[k] < 0) continue;
        diff = now - (stamp_q[oldest[k]] + tmo);
        if (diff != 0 && !diff[31]) begin
          vld[oldest[k]] = 0;
          if (total > 0) total--;
          n_aged++;
        end
      end
    endfunction

    function void note_item(logic [2:0] fn, logic [47:0] m, logic [2:0] p,
                            logic [31:0] now);
      status_t     r;
      int          s;
      int unsigned lim;
      r = '0;
      lim = (limit_reg > Entries) ? Entries : limit_reg;
      case (fn)
        FUNC_LEARN: begin
          n_learn++;
          expire(now);
          s = find(m);
          if (s >= 0) r.found = 1;
          else if (total < lim) begin
            for (int i = 0; i < Entries; i++) if (!vld[i]) begin
              s = i;
              break;
            end
            if (s >= 0) begin
              vld[s] = 1;
              mac_q[s] = m;
              total++;
            end else r.dropped = 1;
          end else r.dropped = 1;
          if (r.dropped) n_drop++;
          if (s >= 0) begin
            port_q[s] = p;
            stamp_q[s] = now;
            order_q[s] = refresh_cnt;
            refresh_cnt++;
          end
        end
        FUNC_LOOKUP: begin
          s = find(m);
          r.found = s >= 0;
          r.forward = m[McastBit] || (s >= 0 && port_q[s] == p);
          if (s >= 0) n_hit++;
        end
        FUNC_DELETE: begin
          s = find(m);
          if (s >= 0) begin
            r.found = 1;
            vld[s] = 0;
            if (total > 0) total--;
          end
        end
        FUNC_AGE: expire(now);
        FUNC_CLEAR: begin
          foreach (vld[i]) vld[i] = 0;
          total = 0;
        end
        default: ;
      endcase
      r.entry_count = total[8:0];
      pending.push_back(r);
    endfunction

    function void check_status(status_t got);
      status_t e;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t unexpected status beat %h", $time, got);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.forward !== e.forward)
        $display("%0t forward exp %0d got %0d", $time, e.forward, got.forward);
      if (got.found !== e.found)
        $display("%0t found exp %0d got %0d", $time, e.found, got.found);
      if (got.dropped !== e.dropped)
        $display("%0t dropped exp %0d got %0d", $time, e.dropped, got.dropped);
      if (got.entry_count !== e.entry_count)
        $display("%0t entry_count exp %0d got %0d", $time, e.entry_count,
                 got.entry_count);
      if (got !== e) errors++;
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        s_axis_tvalid = 0;
  logic        s_axis_tready;
  logic [87:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 0;
  logic [15:0] m_axis_tdata;
  logic        cfg_valid_i = 0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  table_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_off = 0;
  int unsigned quiet_cycles = 0;
  int unsigned n_items = 0;
  logic [31:0] tick = 0;
  logic [47:0] known_macs[$];

  mac_learning_table uut (.*);

  initial forever #1 clk_i = ~clk_i;

  // receiver side, with stalls and an optional long hold-off
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_status(m_axis_tdata[11:0]);
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        m_axis_tready <= 0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > StallLimit) begin
      $display("%0t watchdog: no progress", $time);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_item(logic [2:0] fn, logic [47:0] m, logic [2:0] p,
                           logic [31:0] now);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    s_axis_tvalid <= 1;
    s_axis_tuser <= fn;
    s_axis_tdata <= {5'd0, now, p, m};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(fn, m, p, now);
    n_items++;
    s_axis_tvalid <= 0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (2 * Entries + Buckets + 20) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [31:0] val);
    cfg_valid_i <= 1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, val);
    cfg_valid_i <= 0;
    @(posedge clk_i);
  endtask

  function automatic logic [47:0] pick_mac();
    logic [47:0] m;
    if (known_macs.size() > 0 && $urandom_range(99) < 60)
      return known_macs[$urandom_range(known_macs.size() - 1)];
    m = {$urandom, $urandom};
    if ($urandom_range(3) != 0) m[40] = 0;
    if (known_macs.size() < 400) known_macs.push_back(m);
    return m;
  endfunction

  task automatic random_items(int unsigned n);
    int unsigned  w;
    logic [2:0]   fn;
    for (int unsigned k = 0; k < n; k++) begin
      w = $urandom_range(99);
      fn = w < 50 ? FUNC_LEARN : w < 75 ? FUNC_LOOKUP : w < 88 ? FUNC_DELETE :
           w < 96 ? FUNC_AGE : w < 98 ? FUNC_CLEAR : 3'($urandom_range(5, 7));
      tick = tick + $urandom_range(400);
      send_item(fn, pick_mac(), 3'($urandom), tick);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    sb.clear_all();
    @(posedge clk_i);

    // directed
    send_item(FUNC_LEARN, 48'h0, 3'd0, 32'd0);
    send_item(FUNC_LEARN, 48'hFFFF_FFFF_FFFF, 3'd7, 32'hFFFF_FFFF);
    send_item(FUNC_LOOKUP, 48'h0, 3'd0, 32'd1);
    send_item(FUNC_LOOKUP, 48'h0, 3'd5, 32'd1);
    send_item(FUNC_LOOKUP, 48'h0100_0000_0000, 3'd2, 32'd1);
    send_item(FUNC_LOOKUP, 48'h1234_5678_9A00, 3'd2, 32'd1);
    send_item(FUNC_LEARN, 48'h0, 3'd3, 32'd10);
    send_item(FUNC_DELETE, 48'hFFFF_FFFF_FFFF, 3'd0, 32'd11);
    send_item(FUNC_DELETE, 48'hFFFF_FFFF_FFFF, 3'd0, 32'd11);
    send_item(FUNC_AGE, 48'h0, 3'd0, 32'd300010);
    send_item(FUNC_AGE, 48'h0, 3'd0, 32'd300011);
    send_item(FUNC_LEARN, 48'hAAAA_AAAA_AA10, 3'd1, 32'hFFFF_FFF0);
    send_item(FUNC_AGE, 48'h0, 3'd0, 32'd300100);
    send_item(3'd5, 48'h5555_5555_5555, 3'd4, 32'd0);
    send_item(3'd7, 48'h0, 3'd0, 32'd0);
    send_item(FUNC_CLEAR, 48'h0, 3'd0, 32'd0);
    drain();

    // tiny limit, full table drops
    write_cfg(REG_ENTRY_LIMIT, 32'd2);
    for (int i = 0; i < 4; i++) send_item(FUNC_LEARN, 48'(i * 17), 3'(i), 32'd5);
    drain();
    write_cfg(REG_ENTRY_LIMIT, 32'd0);
    send_item(FUNC_LEARN, 48'h77, 3'd1, 32'd6);
    send_item(FUNC_LEARN, 48'h0, 3'd1, 32'd6);
    drain();

    // phase: defaults, no idling
    write_cfg(REG_ENTRY_LIMIT, 32'd256);
    random_items(200);
    // long receiver hold-off while sender keeps going
    hold_off = 3000;
    random_items(20);
    drain();

    // tiny long timeout, maximal short timeout, crowded as soon as an entry exists
    write_cfg(REG_LONG_TIMEOUT, 32'd1);
    write_cfg(REG_SHORT_TIMEOUT, 32'hFFFF_FFFF);
    write_cfg(REG_CROWD_LEVEL, 32'd0);
    send_idle_pct = 82;
    random_items(200);
    drain();

    write_cfg(REG_LONG_TIMEOUT, 32'd2000);
    write_cfg(REG_SHORT_TIMEOUT, 32'd300);
    write_cfg(REG_CROWD_LEVEL, 32'd256);
    write_cfg(REG_ENTRY_LIMIT, 32'd20);
    send_idle_pct = 0;
    recv_stall_pct = 82;
    random_items(200);
    drain();

    write_cfg(REG_LONG_TIMEOUT, 32'hFFFF_FFFF);
    write_cfg(REG_SHORT_TIMEOUT, 32'd1);
    write_cfg(REG_CROWD_LEVEL, 32'd8);
    write_cfg(REG_ENTRY_LIMIT, 32'd300);
    send_idle_pct = 17;
    recv_stall_pct = 17;
    random_items(250);
    drain();

    write_cfg(REG_LONG_TIMEOUT, 32'd800);
    write_cfg(REG_SHORT_TIMEOUT, 32'd150);
    write_cfg(REG_CROWD_LEVEL, 32'd40);
    write_cfg(REG_ENTRY_LIMIT, 32'd256);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_items(200);
    drain();

    $display("covered %0d beats (%0d learns, %0d drops, %0d lookup hits, %0d aged out)",
             n_items, sb.n_learn, sb.n_drop, sb.n_hit, sb.n_aged);
    $display("%0d status beats checked, %0d mismatches", sb.checked, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
